// ===== sv/cpcr_pkg.sv =====
// capsule pair collision response: shared widths, latencies and select codes
// no dependencies; imported by every module of the block

package cpcr_pkg;

   localparam int COORD_W   = 16;
   localparam int FRAC_BITS = 4;
   localparam int DIFF_W    = COORD_W + 1;
   localparam int MID_W     = COORD_W + 2;
   localparam int LEN_W     = 2 * COORD_W + 1;
   localparam int RAD_W     = 14;
   localparam int REST_W    = 9;
   localparam int CSR_IDX_W = 2;

   localparam int NUM_W = 61;
   localparam int DEN_W = 45;
   localparam int Q_W   = 18;
   localparam int REM_W = DEN_W + Q_W;
   localparam int IMP_W = Q_W + 1;

   localparam int FRONT_LAT = 6;
   localparam int DIV_LAT   = Q_W + 1;
   localparam int NEAR_LAT  = FRONT_LAT + DIV_LAT + 1;
   localparam int PIPE_LAT  = NEAR_LAT + 3;

   localparam int REQ_W = 12 * COORD_W;
   localparam int RSP_W = ((2 + 4 * COORD_W + 7) / 8) * 8;

   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS_ONE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS_TWO  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RESTITUTION = 2'd2;

   localparam logic [RAD_W-1:0]  RADIUS_RESET      = 14'd640;
   localparam logic [REST_W-1:0] RESTITUTION_RESET = 9'd230;

   typedef logic [1:0] sel_type;
   localparam sel_type SEL_A   = 2'd0;
   localparam sel_type SEL_B   = 2'd1;
   localparam sel_type SEL_MID = 2'd2;

endpackage

// ===== sv/capsule_pair_collision_response.sv =====
// capsule pair collision response, top level: register file, pipeline, output skid
// depends on cpcr_pkg, cpcr_near, cpcr_imp

// One capsule pair enters per clock while the skid stage is empty; a full stream
// sustains one result per clock while rsp_tready is high; depth is set by the 19-stage
// restoring dividers (closest point and impulse), one quotient bit per stage plus a
// rounding stage, with six stages of products ahead of them and four stages of point
// selection and overlap test behind; the velocity update feeds the result register.
// A result register and a one-entry skid stage follow the pipeline, so a new request
// is taken while a result waits; the whole pipeline holds only once the skid stage
// is full. Radii and restitution are read live and are to be written only while the
// block is empty.

module capsule_pair_collision_response
   import cpcr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // one_a_x, one_a_y, one_b_x, one_b_y, two_a_x, two_a_y, two_b_x, two_b_y,
   // one_vel_x, one_vel_y, two_vel_x, two_vel_y
   input  logic [REQ_W-1:0]     req_tdata,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // overlap, impulse_applied, new_one_vel_x, new_one_vel_y, new_two_vel_x,
   // new_two_vel_y, zero fill
   output logic [RSP_W-1:0]     rsp_tdata,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [RAD_W-1:0]     csr_wdata
);

   localparam int SUM_W = IMP_W + 1;
   localparam int E2_W  = 2 * COORD_W + 1;
   localparam int RS_W  = RAD_W + 1;

   typedef struct packed {
      logic signed [COORD_W-1:0] v1x;
      logic signed [COORD_W-1:0] v1y;
      logic signed [COORD_W-1:0] v2x;
      logic signed [COORD_W-1:0] v2y;
   } vel_type;

   typedef struct packed {
      vel_type                 vel;
      logic signed [IMP_W-1:0] ix;
      logic signed [IMP_W-1:0] iy;
      logic                    apply;
   } work_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] v2y;
      logic signed [COORD_W-1:0] v2x;
      logic signed [COORD_W-1:0] v1y;
      logic signed [COORD_W-1:0] v1x;
      logic                      bounce;
      logic                      hit;
   } rsp_type;

   function automatic logic signed [COORD_W-1:0] sat_vel(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] hi;
      logic signed [SUM_W-1:0] lo;
      hi = SUM_W'((1 << (COORD_W - 1)) - 1);
      lo = -SUM_W'(1 << (COORD_W - 1));
      if (v > hi) begin
         sat_vel = hi[COORD_W-1:0];
      end else if (v < lo) begin
         sat_vel = lo[COORD_W-1:0];
      end else begin
         sat_vel = v[COORD_W-1:0];
      end
   endfunction

   logic [RAD_W-1:0]  radius_one_ff, radius_two_ff;
   logic [REST_W-1:0] restitution_ff;

   logic                      adv;
   logic                      vld_ff [PIPE_LAT];
   vel_type                   vel_ff [NEAR_LAT];
   logic signed [COORD_W-1:0] in_f [12];
   logic signed [COORD_W-1:0] c1x, c1y, c2x, c2y;
   logic signed [IMP_W-1:0]   imp_x, imp_y;
   logic                      imp_apply;

   work_type                  f1_ff, f2_ff, f3_ff;
   logic signed [DIFF_W-1:0]  ex1_ff, ey1_ff;
   logic signed [2*DIFF_W-1:0] exx_p, eyy_p;
   logic [E2_W-1:0]           exx2_ff, eyy2_ff;
   logic [RS_W-1:0]           rs;
   logic [2*RS_W-1:0]         rs2_ff;
   logic                      hit3_ff;

   logic signed [SUM_W-1:0]   add_x, add_y;
   rsp_type                   last_rsp;
   rsp_type                   out_ff, skid_ff;
   logic                      out_valid_ff, skid_valid_ff;
   logic                      take_out;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_one_ff  <= RADIUS_RESET;
         radius_two_ff  <= RADIUS_RESET;
         restitution_ff <= RESTITUTION_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_RADIUS_ONE:  radius_one_ff  <= csr_wdata;
            CSR_RADIUS_TWO:  radius_two_ff  <= csr_wdata;
            CSR_RESTITUTION: restitution_ff <= csr_wdata[REST_W-1:0];
            default: ;
         endcase
      end
   end

   for (genvar i = 0; i < 12; i++) begin : g_field
      assign in_f[i] = req_tdata[i*COORD_W +: COORD_W];
   end

   assign adv        = !skid_valid_ff;
   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < PIPE_LAT; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         vld_ff[0] <= req_tvalid;
         for (int k = 1; k < PIPE_LAT; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         vel_ff[0] <= '{v1x: in_f[8], v1y: in_f[9], v2x: in_f[10], v2y: in_f[11]};
         for (int k = 1; k < NEAR_LAT; k++) begin
            vel_ff[k] <= vel_ff[k-1];
         end
      end
   end

   // point on segment one nearest endpoint A of capsule two
   cpcr_near u_near_one (
      .clock (clock),
      .adv   (adv),
      .a_x   (in_f[0]),
      .a_y   (in_f[1]),
      .b_x   (in_f[2]),
      .b_y   (in_f[3]),
      .p_x   (in_f[4]),
      .p_y   (in_f[5]),
      .c_x   (c1x),
      .c_y   (c1y)
   );

   // point on segment two nearest endpoint A of capsule one
   cpcr_near u_near_two (
      .clock (clock),
      .adv   (adv),
      .a_x   (in_f[4]),
      .a_y   (in_f[5]),
      .b_x   (in_f[6]),
      .b_y   (in_f[7]),
      .p_x   (in_f[0]),
      .p_y   (in_f[1]),
      .c_x   (c2x),
      .c_y   (c2y)
   );

   cpcr_imp u_imp (
      .clock       (clock),
      .adv         (adv),
      .restitution (restitution_ff),
      .one_a_x     (in_f[0]),
      .one_a_y     (in_f[1]),
      .one_b_x     (in_f[2]),
      .one_b_y     (in_f[3]),
      .two_a_x     (in_f[4]),
      .two_a_y     (in_f[5]),
      .two_b_x     (in_f[6]),
      .two_b_y     (in_f[7]),
      .one_vel_x   (in_f[8]),
      .one_vel_y   (in_f[9]),
      .two_vel_x   (in_f[10]),
      .two_vel_y   (in_f[11]),
      .imp_x       (imp_x),
      .imp_y       (imp_y),
      .apply       (imp_apply)
   );

   // separation of the nearest points
   always_ff @(posedge clock) begin
      if (adv) begin
         ex1_ff <= DIFF_W'(c1x) - DIFF_W'(c2x);
         ey1_ff <= DIFF_W'(c1y) - DIFF_W'(c2y);
         f1_ff  <= '{vel: vel_ff[NEAR_LAT-1], ix: imp_x, iy: imp_y, apply: imp_apply};
      end
   end

   assign exx_p = ex1_ff * ex1_ff;
   assign eyy_p = ey1_ff * ey1_ff;
   assign rs    = RS_W'(radius_one_ff) + RS_W'(radius_two_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         exx2_ff <= exx_p[E2_W-1:0];
         eyy2_ff <= eyy_p[E2_W-1:0];
         rs2_ff  <= rs * rs;
         f2_ff   <= f1_ff;
      end
   end

   // overlap test
   always_ff @(posedge clock) begin
      if (adv) begin
         hit3_ff <= ((E2_W + 1)'(exx2_ff) + (E2_W + 1)'(eyy2_ff)) < (E2_W + 1)'(rs2_ff);
         f3_ff   <= f2_ff;
      end
   end

   // velocity update with saturation
   assign add_x = (hit3_ff && f3_ff.apply) ? SUM_W'(f3_ff.ix) : '0;
   assign add_y = (hit3_ff && f3_ff.apply) ? SUM_W'(f3_ff.iy) : '0;

   always_comb begin
      last_rsp.hit    = hit3_ff;
      last_rsp.bounce = hit3_ff && f3_ff.apply;
      last_rsp.v1x    = sat_vel(SUM_W'(f3_ff.vel.v1x) + add_x);
      last_rsp.v1y    = sat_vel(SUM_W'(f3_ff.vel.v1y) + add_y);
      last_rsp.v2x    = sat_vel(SUM_W'(f3_ff.vel.v2x) - add_x);
      last_rsp.v2y    = sat_vel(SUM_W'(f3_ff.vel.v2y) - add_y);
   end

   // result register and skid stage
   assign take_out = out_valid_ff && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (take_out || !out_valid_ff) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff  <= vld_ff[PIPE_LAT-1];
         end
      end else if (adv && vld_ff[PIPE_LAT-1]) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (take_out || !out_valid_ff) begin
         out_ff <= skid_valid_ff ? skid_ff : last_rsp;
      end
      if (adv) begin
         skid_ff <= last_rsp;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_W'(out_ff);

endmodule

// ===== sv/cpcr_div.sv =====
// pipelined restoring divider, one quotient bit per stage, rounded to nearest
// depends on cpcr_pkg

module cpcr_div
   import cpcr_pkg::*;
(
   input  logic             clock,
   input  logic             adv,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [Q_W-1:0]   quo
);

   logic [REM_W-1:0] rem_ff [Q_W];
   logic [DEN_W-1:0] den_ff [Q_W];
   logic [Q_W-1:0]   q_ff   [Q_W];
   logic [Q_W-1:0]   quo_ff;
   logic [REM_W:0]   twice_rem;
   logic             round_up;

   for (genvar k = 0; k < Q_W; k++) begin : g_step
      logic [REM_W-1:0] rem_src;
      logic [REM_W-1:0] rem_in;
      logic [DEN_W-1:0] den_src;
      logic [Q_W-1:0]   q_src;
      logic [Q_W-1:0]   q_in;
      logic [REM_W-1:0] den_sh;
      logic [REM_W:0]   diff;

      if (k == 0) begin : g_first
         assign rem_src = REM_W'(num);
         assign den_src = den;
         assign q_src   = '0;
      end else begin : g_next
         assign rem_src = rem_ff[k-1];
         assign den_src = den_ff[k-1];
         assign q_src   = q_ff[k-1];
      end

      assign den_sh = REM_W'(den_src) << (Q_W - 1 - k);
      assign diff   = {1'b0, rem_src} - {1'b0, den_sh};

      always_comb begin
         rem_in = rem_src;
         q_in   = q_src;
         if (!diff[REM_W]) begin
            rem_in            = diff[REM_W-1:0];
            q_in[Q_W - 1 - k] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k] <= rem_in;
            den_ff[k] <= den_src;
            q_ff[k]   <= q_in;
         end
      end
   end

   assign twice_rem = {rem_ff[Q_W-1], 1'b0};
   assign round_up  = twice_rem >= (REM_W + 1)'(den_ff[Q_W-1]);

   always_ff @(posedge clock) begin
      if (adv) begin
         quo_ff <= q_ff[Q_W-1] + Q_W'(round_up);
      end
   end

   assign quo = quo_ff;

endmodule

// ===== sv/cpcr_near.sv =====
// closest point on a segment to a point, parameter clamped to the segment
// depends on cpcr_pkg and cpcr_div

module cpcr_near
   import cpcr_pkg::*;
(
   input  logic                      clock,
   input  logic                      adv,
   input  logic signed [COORD_W-1:0] a_x,
   input  logic signed [COORD_W-1:0] a_y,
   input  logic signed [COORD_W-1:0] b_x,
   input  logic signed [COORD_W-1:0] b_y,
   input  logic signed [COORD_W-1:0] p_x,
   input  logic signed [COORD_W-1:0] p_y,
   output logic signed [COORD_W-1:0] c_x,
   output logic signed [COORD_W-1:0] c_y
);

   localparam int SIDE_LEN = FRONT_LAT + DIV_LAT;
   localparam int SEL_IDX  = 3;
   localparam int S_LO     = 17;
   localparam int S_HI     = LEN_W - S_LO;
   localparam int PROD_W   = 2 * DIFF_W;

   typedef struct packed {
      logic signed [COORD_W-1:0] ax;
      logic signed [COORD_W-1:0] ay;
      logic signed [COORD_W-1:0] bx;
      logic signed [COORD_W-1:0] by;
      sel_type                   sel;
      logic                      neg_x;
      logic                      neg_y;
   } near_side_type;

   near_side_type side_ff [SIDE_LEN];
   near_side_type side_in [SIDE_LEN];
   near_side_type side_out;

   logic signed [DIFF_W-1:0] dx1_ff, dy1_ff, wx1_ff, wy1_ff;
   logic signed [PROD_W-1:0] dxx_p, dyy_p, sx_p, sy_p;
   logic [LEN_W-1:0]         dxx2_ff, dyy2_ff;
   logic signed [PROD_W-1:0] sx2_ff, sy2_ff;
   logic signed [DIFF_W-1:0] dx2_ff, dy2_ff;
   logic [LEN_W-1:0]         len3_ff;
   logic signed [PROD_W:0]   s3_ff;
   logic signed [DIFF_W-1:0] dx3_ff, dy3_ff;
   logic signed [PROD_W:0]   len_s;
   logic signed [DIFF_W-1:0] ndx, ndy;
   sel_type                  sel4_in;
   logic [LEN_W-1:0]         len4_ff, sm4_ff;
   logic [COORD_W-1:0]       adx4_ff, ady4_ff;
   logic [COORD_W+S_LO-1:0]  plx5_ff, ply5_ff;
   logic [COORD_W+S_HI-1:0]  phx5_ff, phy5_ff;
   logic [LEN_W-1:0]         len5_ff, len6_ff;
   logic [NUM_W-1:0]         numx6_ff, numy6_ff;
   logic [Q_W-1:0]           qx, qy;
   logic signed [DIFF_W-1:0] offx, offy, sumx, sumy;
   logic signed [COORD_W-1:0] cx_ff, cy_ff;

   // stage 1: segment and offset vectors
   always_ff @(posedge clock) begin
      if (adv) begin
         dx1_ff <= DIFF_W'(b_x) - DIFF_W'(a_x);
         dy1_ff <= DIFF_W'(b_y) - DIFF_W'(a_y);
         wx1_ff <= DIFF_W'(p_x) - DIFF_W'(a_x);
         wy1_ff <= DIFF_W'(p_y) - DIFF_W'(a_y);
      end
   end

   // stage 2: products
   assign dxx_p = dx1_ff * dx1_ff;
   assign dyy_p = dy1_ff * dy1_ff;
   assign sx_p  = wx1_ff * dx1_ff;
   assign sy_p  = wy1_ff * dy1_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         dxx2_ff <= dxx_p[LEN_W-1:0];
         dyy2_ff <= dyy_p[LEN_W-1:0];
         sx2_ff  <= sx_p;
         sy2_ff  <= sy_p;
         dx2_ff  <= dx1_ff;
         dy2_ff  <= dy1_ff;
      end
   end

   // stage 3: squared length and projection
   always_ff @(posedge clock) begin
      if (adv) begin
         len3_ff <= dxx2_ff + dyy2_ff;
         s3_ff   <= (PROD_W + 1)'(sx2_ff) + (PROD_W + 1)'(sy2_ff);
         dx3_ff  <= dx2_ff;
         dy3_ff  <= dy2_ff;
      end
   end

   // stage 4: clamp decision and magnitudes
   assign len_s = $signed({2'b00, len3_ff});
   assign ndx   = -dx3_ff;
   assign ndy   = -dy3_ff;

   always_comb begin
      if (len3_ff == '0 || s3_ff <= 0) begin
         sel4_in = SEL_A;
      end else if (s3_ff >= len_s) begin
         sel4_in = SEL_B;
      end else begin
         sel4_in = SEL_MID;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         len4_ff <= len3_ff;
         sm4_ff  <= s3_ff[LEN_W-1:0];
         adx4_ff <= dx3_ff[DIFF_W-1] ? ndx[COORD_W-1:0] : dx3_ff[COORD_W-1:0];
         ady4_ff <= dy3_ff[DIFF_W-1] ? ndy[COORD_W-1:0] : dy3_ff[COORD_W-1:0];
      end
   end

   // stage 5: partial products of the numerator
   always_ff @(posedge clock) begin
      if (adv) begin
         plx5_ff <= adx4_ff * sm4_ff[S_LO-1:0];
         phx5_ff <= adx4_ff * sm4_ff[LEN_W-1:S_LO];
         ply5_ff <= ady4_ff * sm4_ff[S_LO-1:0];
         phy5_ff <= ady4_ff * sm4_ff[LEN_W-1:S_LO];
         len5_ff <= len4_ff;
      end
   end

   // stage 6: numerator
   always_ff @(posedge clock) begin
      if (adv) begin
         numx6_ff <= NUM_W'(plx5_ff) + (NUM_W'(phx5_ff) << S_LO);
         numy6_ff <= NUM_W'(ply5_ff) + (NUM_W'(phy5_ff) << S_LO);
         len6_ff  <= len5_ff;
      end
   end

   cpcr_div u_div_x (
      .clock (clock),
      .adv   (adv),
      .num   (numx6_ff),
      .den   (DEN_W'(len6_ff)),
      .quo   (qx)
   );

   cpcr_div u_div_y (
      .clock (clock),
      .adv   (adv),
      .num   (numy6_ff),
      .den   (DEN_W'(len6_ff)),
      .quo   (qy)
   );

   // endpoints and decision travel beside the dividers
   always_comb begin
      side_in[0] = '{ax: a_x, ay: a_y, bx: b_x, by: b_y, sel: SEL_A,
                     neg_x: 1'b0, neg_y: 1'b0};
      for (int k = 1; k < SIDE_LEN; k++) begin
         side_in[k] = side_ff[k-1];
      end
      side_in[SEL_IDX].sel   = sel4_in;
      side_in[SEL_IDX].neg_x = dx3_ff[DIFF_W-1];
      side_in[SEL_IDX].neg_y = dy3_ff[DIFF_W-1];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < SIDE_LEN; k++) begin
            side_ff[k] <= side_in[k];
         end
      end
   end

   // output stage: pick endpoint or interpolated point
   assign side_out = side_ff[SIDE_LEN-1];
   assign offx = side_out.neg_x ? -$signed({1'b0, qx[COORD_W-1:0]})
                                :  $signed({1'b0, qx[COORD_W-1:0]});
   assign offy = side_out.neg_y ? -$signed({1'b0, qy[COORD_W-1:0]})
                                :  $signed({1'b0, qy[COORD_W-1:0]});
   assign sumx = DIFF_W'(side_out.ax) + offx;
   assign sumy = DIFF_W'(side_out.ay) + offy;

   always_ff @(posedge clock) begin
      if (adv) begin
         unique case (side_out.sel)
            SEL_B: begin
               cx_ff <= side_out.bx;
               cy_ff <= side_out.by;
            end
            SEL_MID: begin
               cx_ff <= sumx[COORD_W-1:0];
               cy_ff <= sumy[COORD_W-1:0];
            end
            default: begin
               cx_ff <= side_out.ax;
               cy_ff <= side_out.ay;
            end
         endcase
      end
   end

   assign c_x = cx_ff;
   assign c_y = cy_ff;

endmodule

// ===== sv/cpcr_imp.sv =====
// bounce impulse along the midpoint axis, approach and distance tests
// depends on cpcr_pkg and cpcr_div

module cpcr_imp
   import cpcr_pkg::*;
(
   input  logic                      clock,
   input  logic                      adv,
   input  logic [REST_W-1:0]         restitution,
   input  logic signed [COORD_W-1:0] one_a_x,
   input  logic signed [COORD_W-1:0] one_a_y,
   input  logic signed [COORD_W-1:0] one_b_x,
   input  logic signed [COORD_W-1:0] one_b_y,
   input  logic signed [COORD_W-1:0] two_a_x,
   input  logic signed [COORD_W-1:0] two_a_y,
   input  logic signed [COORD_W-1:0] two_b_x,
   input  logic signed [COORD_W-1:0] two_b_y,
   input  logic signed [COORD_W-1:0] one_vel_x,
   input  logic signed [COORD_W-1:0] one_vel_y,
   input  logic signed [COORD_W-1:0] two_vel_x,
   input  logic signed [COORD_W-1:0] two_vel_y,
   output logic signed [IMP_W-1:0]   imp_x,
   output logic signed [IMP_W-1:0]   imp_y,
   output logic                      apply
);

   localparam int SIDE_LEN = FRONT_LAT + DIV_LAT - 3;
   localparam int D2_W     = 2 * MID_W - 1;
   localparam int RD_W     = DIFF_W + MID_W + 1;
   localparam int K_W      = 44;
   localparam int K_LO     = K_W / 2;
   localparam int EF_W     = REST_W + 1;
   localparam int AD_W     = MID_W - 1;
   localparam logic [D2_W-1:0] PIX2 = D2_W'(4) << (2 * FRAC_BITS);

   typedef struct packed {
      logic apply;
      logic neg_x;
      logic neg_y;
   } imp_side_type;

   imp_side_type side_ff [SIDE_LEN];
   imp_side_type side_out;

   logic signed [MID_W-1:0]    dx1_ff, dy1_ff;
   logic signed [DIFF_W-1:0]   rx1_ff, ry1_ff;
   logic signed [2*MID_W-1:0]  dxx_p, dyy_p;
   logic signed [RD_W-2:0]     rdx_p, rdy_p;
   logic [D2_W-1:0]            dxx2_ff, dyy2_ff;
   logic signed [RD_W-2:0]     rdx2_ff, rdy2_ff;
   logic signed [MID_W-1:0]    dx2_ff, dy2_ff, dx3_ff, dy3_ff;
   logic [D2_W-1:0]            d23_ff, d24_ff, d25_ff, d26_ff;
   logic signed [RD_W-1:0]     rd3_ff;
   logic signed [RD_W-1:0]     nrd;
   logic signed [MID_W-1:0]    ndx, ndy;
   logic [EF_W-1:0]            ef;
   logic [EF_W+RD_W-2:0]       k_p;
   logic [K_W-1:0]             k4_ff;
   logic [AD_W-1:0]            adx4_ff, ady4_ff;
   logic [K_LO+AD_W-1:0]       plx5_ff, phx5_ff, ply5_ff, phy5_ff;
   logic [NUM_W-1:0]           numx6_ff, numy6_ff;
   logic [Q_W-1:0]             qx, qy;
   logic signed [IMP_W-1:0]    ix_ff, iy_ff;
   logic                       apply_ff;

   // stage 1: twice the midpoint offset, relative velocity
   always_ff @(posedge clock) begin
      if (adv) begin
         dx1_ff <= (MID_W'(one_a_x) + MID_W'(one_b_x)) - (MID_W'(two_a_x) + MID_W'(two_b_x));
         dy1_ff <= (MID_W'(one_a_y) + MID_W'(one_b_y)) - (MID_W'(two_a_y) + MID_W'(two_b_y));
         rx1_ff <= DIFF_W'(one_vel_x) - DIFF_W'(two_vel_x);
         ry1_ff <= DIFF_W'(one_vel_y) - DIFF_W'(two_vel_y);
      end
   end

   // stage 2: products
   assign dxx_p = dx1_ff * dx1_ff;
   assign dyy_p = dy1_ff * dy1_ff;
   assign rdx_p = rx1_ff * dx1_ff;
   assign rdy_p = ry1_ff * dy1_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         dxx2_ff <= dxx_p[D2_W-1:0];
         dyy2_ff <= dyy_p[D2_W-1:0];
         rdx2_ff <= rdx_p;
         rdy2_ff <= rdy_p;
         dx2_ff  <= dx1_ff;
         dy2_ff  <= dy1_ff;
      end
   end

   // stage 3: squared axis length and approach speed
   always_ff @(posedge clock) begin
      if (adv) begin
         d23_ff <= dxx2_ff + dyy2_ff;
         rd3_ff <= RD_W'(rdx2_ff) + RD_W'(rdy2_ff);
         dx3_ff <= dx2_ff;
         dy3_ff <= dy2_ff;
      end
   end

   // stage 4: tests and scaled approach speed
   assign nrd = -rd3_ff;
   assign ndx = -dx3_ff;
   assign ndy = -dy3_ff;
   assign ef  = EF_W'(256) + EF_W'(restitution);
   assign k_p = ef * nrd[RD_W-2:0];

   always_ff @(posedge clock) begin
      if (adv) begin
         k4_ff   <= k_p[K_W-1:0];
         adx4_ff <= dx3_ff[MID_W-1] ? ndx[AD_W-1:0] : dx3_ff[AD_W-1:0];
         ady4_ff <= dy3_ff[MID_W-1] ? ndy[AD_W-1:0] : dy3_ff[AD_W-1:0];
         d24_ff  <= d23_ff;
      end
   end

   // stage 5: partial products
   always_ff @(posedge clock) begin
      if (adv) begin
         plx5_ff <= k4_ff[K_LO-1:0] * adx4_ff;
         phx5_ff <= k4_ff[K_W-1:K_LO] * adx4_ff;
         ply5_ff <= k4_ff[K_LO-1:0] * ady4_ff;
         phy5_ff <= k4_ff[K_W-1:K_LO] * ady4_ff;
         d25_ff  <= d24_ff;
      end
   end

   // stage 6: numerator
   always_ff @(posedge clock) begin
      if (adv) begin
         numx6_ff <= NUM_W'(plx5_ff) + (NUM_W'(phx5_ff) << K_LO);
         numy6_ff <= NUM_W'(ply5_ff) + (NUM_W'(phy5_ff) << K_LO);
         d26_ff   <= d25_ff;
      end
   end

   cpcr_div u_div_x (
      .clock (clock),
      .adv   (adv),
      .num   (numx6_ff),
      .den   (DEN_W'(d26_ff) << 9),
      .quo   (qx)
   );

   cpcr_div u_div_y (
      .clock (clock),
      .adv   (adv),
      .num   (numy6_ff),
      .den   (DEN_W'(d26_ff) << 9),
      .quo   (qy)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= '{apply: (d23_ff >= PIX2) && rd3_ff[RD_W-1],
                         neg_x: dx3_ff[MID_W-1], neg_y: dy3_ff[MID_W-1]};
         for (int k = 1; k < SIDE_LEN; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign side_out = side_ff[SIDE_LEN-1];

   always_ff @(posedge clock) begin
      if (adv) begin
         ix_ff    <= side_out.neg_x ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
         iy_ff    <= side_out.neg_y ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
         apply_ff <= side_out.apply;
      end
   end

   assign imp_x = ix_ff;
   assign imp_y = iy_ff;
   assign apply = apply_ff;

endmodule

// ===== tb/tb_capsule_pair_collision_response.sv =====
// testbench for capsule_pair_collision_response: random and directed capsule pairs,
// each result checked against an in-bench collision predictor
// depends on cpcr_pkg and the capsule_pair_collision_response rtl

module tb_capsule_pair_collision_response;
   import cpcr_pkg::*;

   typedef struct {
      logic       overlap;
      logic       impulse;
      logic [COORD_W-1:0] vel [4];
   } velocity_result_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [REQ_W-1:0]     req_tdata = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RSP_W-1:0]     rsp_tdata;
   logic                 csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_RADIUS_ONE;
   logic [RAD_W-1:0]     csr_wdata = '0;

   logic [REQ_W-1:0]     pair_queue [$];
   velocity_result_type  bounce_queue [$];
   longint               rad_one = 640, rad_two = 640, rest_coef = 230;
   int                   send_gap = 0, recv_gap = 0, fail_count = 0;
   bit                   quiet = 1'b0;
   string                vel_name [4] = '{"new_one_vel_x", "new_one_vel_y",
                                          "new_two_vel_x", "new_two_vel_y"};

   capsule_pair_collision_response dut (.*);

   always #10 clock = ~clock;

   function automatic longint rdiv(longint num, longint den);
      longint unsigned mag, q;
      mag = num < 0 ? -num : num;
      q = (2 * mag + den) / (2 * den);
      return num < 0 ? -longint'(q) : longint'(q);
   endfunction

   function automatic void nearest(input longint ax, ay, bx, by, px, py,
                                   output longint qx, qy);
      longint dx, dy, len2, s;
      dx = bx - ax;
      dy = by - ay;
      len2 = dx * dx + dy * dy;
      s = (px - ax) * dx + (py - ay) * dy;
      if (len2 == 0 || s <= 0) begin
         qx = ax; qy = ay;
      end else if (s >= len2) begin
         qx = bx; qy = by;
      end else begin
         qx = ax + rdiv(dx * s, len2);
         qy = ay + rdiv(dy * s, len2);
      end
   endfunction

   function automatic logic [COORD_W-1:0] sat(longint v);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[COORD_W-1:0];
   endfunction

   function automatic velocity_result_type predict_bounce(logic [REQ_W-1:0] d);
      velocity_result_type r;
      longint f [12];
      longint c1x, c1y, c2x, c2y, ex, ey, rs, dx, dy, d2, rd, k, ix, iy;
      for (int i = 0; i < 12; i++) f[i] = $signed(d[16*i +: 16]);
      nearest(f[0], f[1], f[2], f[3], f[4], f[5], c1x, c1y);
      nearest(f[4], f[5], f[6], f[7], f[0], f[1], c2x, c2y);
      ex = c1x - c2x;
      ey = c1y - c2y;
      rs = rad_one + rad_two;
      r.overlap = (ex * ex + ey * ey) < rs * rs;
      r.impulse = 1'b0;
      if (r.overlap) begin
         dx = (f[0] + f[2]) - (f[4] + f[6]);
         dy = (f[1] + f[3]) - (f[5] + f[7]);
         d2 = dx * dx + dy * dy;
         if (d2 >= (longint'(4) << (2 * FRAC_BITS))) begin
            rd = (f[8] - f[10]) * dx + (f[9] - f[11]) * dy;
            if (rd < 0) begin
               k = (256 + rest_coef) * (-rd);
               ix = rdiv(k * dx, 512 * d2);
               iy = rdiv(k * dy, 512 * d2);
               f[8] += ix; f[9] += iy;
               f[10] -= ix; f[11] -= iy;
               r.impulse = 1'b1;
            end
         end
      end
      for (int i = 0; i < 4; i++) r.vel[i] = sat(f[8 + i]);
      return r;
   endfunction

   function automatic logic [REQ_W-1:0] pack_pair(longint f [12]);
      logic [REQ_W-1:0] d;
      for (int i = 0; i < 12; i++) d[16*i +: 16] = sat(f[i]);
      return d;
   endfunction

   function automatic longint srand(int lim);
      return longint'($urandom_range(2 * lim)) - lim;
   endfunction

   // mostly capsules placed near each other, some full-range noise
   function automatic logic [REQ_W-1:0] random_pair();
      longint f [12];
      longint cx, cy;
      int spread, vmax;
      if ($urandom_range(9) == 0) begin
         for (int i = 0; i < 12; i++) f[i] = srand(32768);
         return pack_pair(f);
      end
      cx = srand(30000);
      cy = srand(30000);
      spread = $urandom_range(3) == 0 ? $urandom_range(30000) : $urandom_range(1500);
      vmax = $urandom_range(3) == 0 ? 32768 : $urandom_range(4000);
      for (int i = 0; i < 8; i++) f[i] = ((i % 2) ? cy : cx) + srand(spread);
      if ($urandom_range(7) == 0) begin f[2] = f[0]; f[3] = f[1]; end
      if ($urandom_range(7) == 0) begin f[6] = f[4]; f[7] = f[5]; end
      for (int i = 8; i < 12; i++) f[i] = srand(vmax);
      return pack_pair(f);
   endfunction

   task automatic add_pair(longint a1x, a1y, b1x, b1y, a2x, a2y, b2x, b2y,
                           v1x, v1y, v2x, v2y);
      longint f [12];
      f = '{a1x, a1y, b1x, b1y, a2x, a2y, b2x, b2y, v1x, v1y, v2x, v2y};
      pair_queue.push_back(pack_pair(f));
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, longint val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[RAD_W-1:0];
      case (idx)
         CSR_RADIUS_ONE:  rad_one = val;
         CSR_RADIUS_TWO:  rad_two = val;
         default:         rest_coef = val;
      endcase
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic drain();
      while (pair_queue.size() != 0 || bounce_queue.size() != 0) @(posedge clock);
      repeat (PIPE_LAT + 10) @(posedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_tvalid <= 1'b0;
         end else if (pair_queue.size() != 0) begin
            req_tdata <= pair_queue.pop_front();
            req_tvalid <= 1'b1;
            if (!quiet && $urandom_range(5) == 0) send_gap <= $urandom_range(1, 17);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // response monitor and receiver stalls
   always @(posedge clock) begin
      velocity_result_type e;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) bounce_queue.push_back(predict_bounce(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (bounce_queue.size() == 0) begin
               $error("unexpected response %h", rsp_tdata);
               fail_count++;
            end else begin
               e = bounce_queue.pop_front();
               if (rsp_tdata[0] !== e.overlap) begin
                  $error("overlap exp %0d got %0d", e.overlap, rsp_tdata[0]);
                  fail_count++;
               end
               if (rsp_tdata[1] !== e.impulse) begin
                  $error("impulse_applied exp %0d got %0d", e.impulse, rsp_tdata[1]);
                  fail_count++;
               end
               for (int i = 0; i < 4; i++)
                  if (rsp_tdata[2 + 16*i +: 16] !== e.vel[i]) begin
                     $error("%s exp %0d got %0d", vel_name[i],
                            $signed(e.vel[i]), $signed(rsp_tdata[2 + 16*i +: 16]));
                     fail_count++;
                  end
            end
         end
         if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            rsp_tready <= 1'b0;
         end else if (!quiet && $urandom_range(7) == 0) begin
            recv_gap <= $urandom_range(0, 16);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      #50_000_000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      longint rad_set [5][3];
      rad_set = '{'{640, 640, 230}, '{0, 0, 0}, '{16383, 16383, 256},
                  '{100, 300, 511}, '{400, 250, 128}};
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: approaching, separating, coincident, zero length, extremes
      add_pair(0, 0, 160, 0, 200, 0, 360, 0, 320, 0, -320, 0);
      add_pair(0, 0, 160, 0, 200, 0, 360, 0, -320, 0, 320, 0);
      add_pair(0, 0, 160, 0, 200, 0, 360, 0, 0, 500, 0, -500);
      add_pair(0, 0, 160, 160, 0, 0, 160, 160, 100, 0, -100, 0);
      add_pair(10, 10, 10, 10, 30, 40, 30, 40, 50, 50, -50, -50);
      add_pair(10, 10, 10, 10, 0, 0, 400, 0, 0, -90, 0, 90);
      add_pair(0, 0, 0, 400, 10, 10, 10, 10, 30, 0, -30, 0);
      add_pair(0, 0, 8, 0, 8, 0, 16, 0, 500, 0, -500, 0);
      add_pair(-32768, -32768, 32767, 32767, 32767, -32768, -32768, 32767,
               32767, 32767, -32768, -32768);
      add_pair(0, 0, 320, 0, 300, 0, 620, 0, 32767, -32768, -32768, 32767);
      add_pair(0, 0, 320, 0, 300, 0, 620, 0, -32768, 32767, 32767, -32768);
      add_pair(-32768, 0, -32768, 0, 32767, 0, 32767, 0, 32767, 0, -32768, 0);
      add_pair(0, 0, 500, 0, 250, -300, 250, 300, 0, 0, 0, 0);
      add_pair(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1);
      add_pair(0, 0, 100, 0, 0, 0, 0, 100, 0, 0, 0, 0);

      for (int p = 0; p < 5; p++) begin
         drain();
         write_csr(CSR_RADIUS_ONE, rad_set[p][0]);
         write_csr(CSR_RADIUS_TWO, rad_set[p][1]);
         write_csr(CSR_RESTITUTION, rad_set[p][2]);
         if (p < 4) add_pair(0, 0, 320, 0, 300, 0, 620, 0, 32767, -32768, -32768, 32767);
         if (p == 4) quiet = 1'b1;
         for (int i = 0; i < 285; i++) pair_queue.push_back(random_pair());
      end
      drain();
      if (fail_count == 0 && bounce_queue.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
